/* hw/rtl/lc3b_pkg.sv */
// Shared types and constants for the LC-3b instruction executor.
// No dependencies.
`default_nettype none
package lc3b_pkg;
    localparam int MEM_WORDS_DEF = 32768;
    localparam int NUM_REGS_DEF = 8;
    localparam logic [15:0] START_PC_RST = 16'h3000;
    localparam logic [2:0] CC_Z = 3'b010;

    localparam logic [3:0] OP_BR = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_LDB = 4'd2;
    localparam logic [3:0] OP_STB = 4'd3;
    localparam logic [3:0] OP_JSR = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_LDW = 4'd6;
    localparam logic [3:0] OP_STW = 4'd7;
    localparam logic [3:0] OP_XOR = 4'd9;
    localparam logic [3:0] OP_JMP = 4'd12;
    localparam logic [3:0] OP_SHF = 4'd13;
    localparam logic [3:0] OP_LEA = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    typedef struct packed {
        logic [15:0] pc;
        logic        halted;
        logic [2:0]  cond_codes;
        logic        reg_write;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic [1:0]  mem_write;
        logic [14:0] mem_word_addr;
        logic [15:0] mem_data;
    } result_t;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        if (v[15]) return 3'b100;
        if (v == 16'd0) return 3'b010;
        return 3'b001;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/lc3b_instruction_executor.sv */
// Top level of the LC-3b instruction executor: sequencer, register file, word memory.
// Depends on lc3b_pkg.
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tdata[14:0]=load_addr,[30:15]=load_data; tuser=func
// m_axis   out  tvalid/tready    tdata = result fields, pc in lowest bits
// cfg      in   cfg_valid/ready  cfg_data = start_pc
//
// A load, or a step while halted, passes S_FETCH and S_DONE; a step passes fetch
// read, decode with data read, execute and writeback, result. The input is ready
// again as the result register loads, so no item is taken before the last is done.
// A full output register holds the finished item in S_DONE.
// Reset: registers zero, PC = 0x3000, Z set; memory content undefined until written.
`default_nettype none
module lc3b_instruction_executor #(
    parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS = lc3b_pkg::NUM_REGS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // load_addr, load_data (lowest first), zero fill
    input  wire logic        s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pc, halted, cond_codes, reg_write, reg_index, reg_value, mem_write,
    // mem_word_addr, mem_data (lowest first), zero fill
    output logic [79:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_EXEC, S_DATA, S_DONE} state_t;

    state_t              state_reg;
    logic [15:0]         mem [MEM_WORDS];
    logic [15:0]         rdata_reg;
    logic [15:0]         regs_reg [NUM_REGS];
    logic [15:0]         pc_reg;
    logic [2:0]          cc_reg;
    logic [15:0]         ir_reg;
    logic [15:0]         addr_reg;
    logic                func_reg;
    logic [14:0]         laddr_reg;
    logic [15:0]         ldata_reg;
    lc3b_pkg::result_t   work_reg;
    lc3b_pkg::result_t   res_reg;
    lc3b_pkg::result_t   res_next;
    lc3b_pkg::result_t   load_res;
    lc3b_pkg::result_t   exe_res;
    logic [15:0]         exe_pc;
    logic                exe_setcc;
    logic                out_valid_reg;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [15:0]         mem_wdata;

    logic [3:0]          op;
    logic [2:0]          dr;
    logic [15:0]         ra;
    logic [15:0]         rd;
    logic [15:0]         opb;
    logic [15:0]         nxt;
    logic [15:0]         br_off;
    logic [15:0]         jsr_off;
    logic [15:0]         shres;
    logic [15:0]         byte_ld;
    logic [3:0]          fet_op;
    logic [15:0]         fet_base;
    logic [15:0]         ea;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, res_reg.mem_data, res_reg.mem_word_addr, res_reg.mem_write,
        res_reg.reg_value, res_reg.reg_index, res_reg.reg_write, res_reg.cond_codes,
        res_reg.halted, res_reg.pc};

    assign op = ir_reg[15:12];
    assign dr = ir_reg[11:9];
    assign ra = regs_reg[ir_reg[8:6]];
    assign rd = regs_reg[dr];
    assign opb = ir_reg[5] ? {{11{ir_reg[4]}}, ir_reg[4:0]} : regs_reg[ir_reg[2:0]];
    assign nxt = pc_reg + 16'd2;
    assign br_off = {{6{ir_reg[8]}}, ir_reg[8:0], 1'b0};
    assign jsr_off = {{4{ir_reg[10]}}, ir_reg[10:0], 1'b0};
    assign byte_ld = addr_reg[0] ? {{8{rdata_reg[15]}}, rdata_reg[15:8]}
                                 : {{8{rdata_reg[7]}}, rdata_reg[7:0]};

    assign fet_op = rdata_reg[15:12];
    assign fet_base = regs_reg[rdata_reg[8:6]];
    assign ea = (fet_op == lc3b_pkg::OP_LDB || fet_op == lc3b_pkg::OP_STB)
        ? fet_base + {{10{rdata_reg[5]}}, rdata_reg[5:0]}
        : fet_base + {{9{rdata_reg[5]}}, rdata_reg[5:0], 1'b0};

    always_comb
    begin
        if (!ir_reg[4])
            shres = ra << ir_reg[3:0];
        else if (!ir_reg[5])
            shres = ra >> ir_reg[3:0];
        else
            shres = 16'($signed(ra) >>> ir_reg[3:0]);
    end

    always_comb
    begin
        mem_raddr = pc_reg[AW:1];
        if (state_reg == S_EXEC)
        begin
            if (fet_op == lc3b_pkg::OP_TRAP)
                mem_raddr = AW'(rdata_reg[7:0]);
            else
                mem_raddr = ea[AW:1];
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = laddr_reg[AW-1:0];
        mem_wdata = ldata_reg;
        if (state_reg == S_FETCH && !func_reg)
            mem_we = 1'b1;
        else if (state_reg == S_DATA && op == lc3b_pkg::OP_STW)
        begin
            mem_we = 1'b1;
            mem_waddr = addr_reg[AW:1];
            mem_wdata = rd;
        end
        else if (state_reg == S_DATA && op == lc3b_pkg::OP_STB)
        begin
            mem_we = 1'b1;
            mem_waddr = addr_reg[AW:1];
            mem_wdata = addr_reg[0] ? {rd[7:0], rdata_reg[7:0]} : {rdata_reg[15:8], rd[7:0]};
        end
    end

    always_comb
    begin
        load_res = '0;
        load_res.mem_write = 2'd3;
        load_res.mem_word_addr = 15'(laddr_reg[AW-1:0]);
        load_res.mem_data = ldata_reg;
    end

    always_comb
    begin
        exe_res = '0;
        exe_pc = nxt;
        exe_setcc = 1'b0;
        case (op)
            lc3b_pkg::OP_BR:
                if ((dr & cc_reg) != 3'd0)
                    exe_pc = nxt + br_off;
            lc3b_pkg::OP_ADD:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = ra + opb;
                exe_setcc = 1'b1;
            end
            lc3b_pkg::OP_AND:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = ra & opb;
                exe_setcc = 1'b1;
            end
            lc3b_pkg::OP_XOR:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = ra ^ opb;
                exe_setcc = 1'b1;
            end
            lc3b_pkg::OP_SHF:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = shres;
                exe_setcc = 1'b1;
            end
            lc3b_pkg::OP_LDW:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = rdata_reg;
                exe_setcc = 1'b1;
            end
            lc3b_pkg::OP_LDB:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = byte_ld;
                exe_setcc = 1'b1;
            end
            lc3b_pkg::OP_LEA:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = dr;
                exe_res.reg_value = nxt + br_off;
            end
            lc3b_pkg::OP_JMP:
                exe_pc = ra;
            lc3b_pkg::OP_JSR:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = 3'd7;
                exe_res.reg_value = nxt;
                exe_pc = ir_reg[11] ? nxt + jsr_off : ra;
            end
            lc3b_pkg::OP_TRAP:
            begin
                exe_res.reg_write = 1'b1;
                exe_res.reg_index = 3'd7;
                exe_res.reg_value = nxt;
                exe_pc = rdata_reg;
            end
            lc3b_pkg::OP_STW:
            begin
                exe_res.mem_write = 2'd3;
                exe_res.mem_word_addr = 15'(addr_reg[AW:1]);
                exe_res.mem_data = rd;
            end
            lc3b_pkg::OP_STB:
            begin
                exe_res.mem_write = addr_reg[0] ? 2'd2 : 2'd1;
                exe_res.mem_word_addr = 15'(addr_reg[AW:1]);
                exe_res.mem_data = addr_reg[0] ? {rd[7:0], 8'd0} : {8'd0, rd[7:0]};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res_next = work_reg;
        res_next.pc = pc_reg;
        res_next.halted = (pc_reg == 16'd0);
        res_next.cond_codes = cc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= lc3b_pkg::START_PC_RST;
            cc_reg <= lc3b_pkg::CC_Z;
            out_valid_reg <= 1'b0;
            work_reg <= '0;
            res_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= 16'd0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                        pc_reg <= cfg_data;
                    if (s_axis_tvalid && s_axis_tready)
                        state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_DONE;
                    if (!func_reg)
                        work_reg <= load_res;
                    else if (pc_reg == 16'd0)
                        work_reg <= '0;
                    else
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                    state_reg <= S_DATA;
                S_DATA:
                begin
                    state_reg <= S_DONE;
                    pc_reg <= exe_pc;
                    work_reg <= exe_res;
                    if (exe_res.reg_write)
                        regs_reg[exe_res.reg_index] <= exe_res.reg_value;
                    if (exe_setcc)
                        cc_reg <= lc3b_pkg::cc_of(exe_res.reg_value);
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        res_reg <= res_next;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg <= s_axis_tuser;
            laddr_reg <= s_axis_tdata[14:0];
            ldata_reg <= s_axis_tdata[30:15];
        end
        if (state_reg == S_EXEC)
        begin
            ir_reg <= rdata_reg;
            addr_reg <= ea;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (res_reg.halted == (res_reg.pc == 16'd0)))
        else $error("halted flag wrong");
endmodule
`default_nettype wire

/* tb/lc3b_instruction_executor_tb.sv */
// Self-checking testbench for lc3b_instruction_executor: directed program, then random programs.
// Predicts each result with an in-bench instruction executor; needs lc3b_pkg and the DUT.
`timescale 1ns / 100ps
module lc3b_instruction_executor_tb;

    typedef struct {
        bit                func;
        logic [14:0]       addr;
        logic [15:0]       data;
        bit                chk;
        lc3b_pkg::result_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;  // load_addr, load_data (lowest first), zero fill
    logic        s_axis_tuser;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;  // pc, halted, cond_codes, reg_write, reg_index, reg_value,
                                // mem_write, mem_word_addr, mem_data, zero fill
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [15:0] mem_m [0:32767];
    bit          mem_ok [0:32767];
    logic [15:0] regs_m [0:7];
    logic [15:0] pc_m;
    logic [2:0]  cc_m;
    logic [15:0] start_m;

    lc3b_pkg::result_t pending_results[$];
    int          fails = 0;
    int          src_pct = 0;
    int          snk_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    lc3b_instruction_executor DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("lc3b_instruction_executor_tb: FAIL");
        $finish;
    end

    function automatic logic [15:0] sext(logic [15:0] v, int n);
        logic [15:0] t;
        t = v << (16 - n);
        return $signed(t) >>> (16 - n);
    endfunction

    function automatic lc3b_pkg::result_t execute_item(bit f, logic [14:0] la,
                                                       logic [15:0] ld);
        lc3b_pkg::result_t r;
        logic [15:0] ir, nxt, a, b, res, ad, w;
        logic [7:0]  bt;
        logic [2:0]  dr;
        bit          rw, setcc;
        r = '0;
        if (!f)
        begin
            mem_m[la] = ld;
            mem_ok[la] = 1'b1;
            r.mem_write = 2'd3;
            r.mem_word_addr = la;
            r.mem_data = ld;
        end
        else if (pc_m != 16'd0)
        begin
            ir = mem_m[pc_m[15:1]];
            nxt = pc_m + 16'd2;
            dr = ir[11:9];
            a = regs_m[ir[8:6]];
            b = ir[5] ? sext(ir, 5) : regs_m[ir[2:0]];
            rw = 1'b0;
            setcc = 1'b0;
            res = '0;
            case (ir[15:12])
                lc3b_pkg::OP_BR:
                    if ((ir[11:9] & cc_m) != 3'd0) nxt = nxt + (sext(ir, 9) << 1);
                lc3b_pkg::OP_ADD:
                begin
                    res = a + b; rw = 1'b1; setcc = 1'b1;
                end
                lc3b_pkg::OP_AND:
                begin
                    res = a & b; rw = 1'b1; setcc = 1'b1;
                end
                lc3b_pkg::OP_XOR:
                begin
                    res = a ^ b; rw = 1'b1; setcc = 1'b1;
                end
                lc3b_pkg::OP_SHF:
                begin
                    if (!ir[4]) res = a << ir[3:0];
                    else if (!ir[5]) res = a >> ir[3:0];
                    else res = $signed(a) >>> ir[3:0];
                    rw = 1'b1; setcc = 1'b1;
                end
                lc3b_pkg::OP_LDB:
                begin
                    ad = a + sext(ir, 6);
                    w = mem_m[ad[15:1]];
                    res = sext({8'h00, ad[0] ? w[15:8] : w[7:0]}, 8);
                    rw = 1'b1; setcc = 1'b1;
                end
                lc3b_pkg::OP_LDW:
                begin
                    ad = a + (sext(ir, 6) << 1);
                    res = mem_m[ad[15:1]];
                    rw = 1'b1; setcc = 1'b1;
                end
                lc3b_pkg::OP_STB:
                begin
                    ad = a + sext(ir, 6);
                    bt = regs_m[dr][7:0];
                    r.mem_word_addr = ad[15:1];
                    if (ad[0])
                    begin
                        r.mem_write = 2'd2;
                        r.mem_data = {bt, 8'h00};
                        mem_m[ad[15:1]][15:8] = bt;
                    end
                    else
                    begin
                        r.mem_write = 2'd1;
                        r.mem_data = {8'h00, bt};
                        mem_m[ad[15:1]][7:0] = bt;
                    end
                end
                lc3b_pkg::OP_STW:
                begin
                    ad = a + (sext(ir, 6) << 1);
                    r.mem_write = 2'd3;
                    r.mem_word_addr = ad[15:1];
                    r.mem_data = regs_m[dr];
                    mem_m[ad[15:1]] = regs_m[dr];
                    mem_ok[ad[15:1]] = 1'b1;
                end
                lc3b_pkg::OP_JSR:
                begin
                    res = nxt;
                    if (ir[11]) nxt = nxt + (sext(ir, 11) << 1);
                    else nxt = a;
                    dr = 3'd7; rw = 1'b1;
                end
                lc3b_pkg::OP_JMP:
                    nxt = a;
                lc3b_pkg::OP_LEA:
                begin
                    res = nxt + (sext(ir, 9) << 1); rw = 1'b1;
                end
                lc3b_pkg::OP_TRAP:
                begin
                    dr = 3'd7; res = nxt; rw = 1'b1;
                    nxt = mem_m[{7'd0, ir[7:0]}];
                end
                default: ;
            endcase
            if (rw)
            begin
                regs_m[dr] = res;
                r.reg_write = 1'b1;
                r.reg_index = dr;
                r.reg_value = res;
            end
            if (setcc) cc_m = res[15] ? 3'b100 : (res == 16'd0 ? 3'b010 : 3'b001);
            pc_m = nxt;
        end
        r.pc = pc_m;
        r.halted = (pc_m == 16'd0);
        r.cond_codes = cc_m;
        return r;
    endfunction

    task automatic send(bit f, logic [14:0] la, logic [15:0] ld, bit chk = 0,
                        lc3b_pkg::result_t typed = '0);
        lc3b_pkg::result_t r;
        r = execute_item(f, la, ld);
        pending_results.push_back(chk ? typed : r);
        if ($urandom_range(99) < src_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, ld, la};
        s_axis_tuser <= f;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_start_pc(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_m = v;
        pc_m = v;
    endtask

    task automatic ensure_word(logic [14:0] wa);
        if (!mem_ok[wa]) send(1'b0, wa, 16'($urandom));
    endtask

    task automatic check_field(string name, int e, int a);
        if (e != a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        lc3b_pkg::result_t e, g;
        bit      rdy;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            g.pc = m_axis_tdata[15:0];
            g.halted = m_axis_tdata[16];
            g.cond_codes = m_axis_tdata[19:17];
            g.reg_write = m_axis_tdata[20];
            g.reg_index = m_axis_tdata[23:21];
            g.reg_value = m_axis_tdata[39:24];
            g.mem_write = m_axis_tdata[41:40];
            g.mem_word_addr = m_axis_tdata[56:42];
            g.mem_data = m_axis_tdata[72:57];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                fails++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("pc", e.pc, g.pc);
                check_field("halted", e.halted, g.halted);
                check_field("cond_codes", e.cond_codes, g.cond_codes);
                check_field("reg_write", e.reg_write, g.reg_write);
                check_field("reg_index", e.reg_index, g.reg_index);
                check_field("reg_value", e.reg_value, g.reg_value);
                check_field("mem_write", e.mem_write, g.mem_write);
                check_field("mem_word_addr", e.mem_word_addr, g.mem_word_addr);
                check_field("mem_data", e.mem_data, g.mem_data);
            end
        end
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request <= 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else
            rdy = ($urandom_range(99) >= snk_pct);
        m_axis_tready <= rdy;
    end

    initial
    begin
        row_t              rows[$];
        lc3b_pkg::result_t ld_ok;
        logic [15:0]       ir, a, ad;
        logic [15:0]       cfg_vals[4];
        int                sent;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        foreach (mem_ok[i]) mem_ok[i] = 1'b0;
        foreach (regs_m[i]) regs_m[i] = '0;
        start_m = lc3b_pkg::START_PC_RST;
        pc_m = lc3b_pkg::START_PC_RST;
        cc_m = 3'b010;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ld_ok = '0;
        ld_ok.pc = 16'h3000;
        ld_ok.cond_codes = 3'b010;
        ld_ok.mem_write = 2'd3;
        rows.push_back('{1'b0, 15'h1800, 16'h127F, 1'b1,
                         lc3b_pkg::result_t'{16'h3000, 1'b0, 3'b010, 1'b0, 3'd0, 16'h0,
                                             2'd3, 15'h1800, 16'h127F}});
        rows.push_back('{1'b0, 15'h7FFF, 16'hFFFF, 1'b1,
                         lc3b_pkg::result_t'{16'h3000, 1'b0, 3'b010, 1'b0, 3'd0, 16'h0,
                                             2'd3, 15'h7FFF, 16'hFFFF}});
        rows.push_back('{1'b0, 15'h0000, 16'h0000, 1'b1,
                         lc3b_pkg::result_t'{16'h3000, 1'b0, 3'b010, 1'b0, 3'd0, 16'h0,
                                             2'd3, 15'h0000, 16'h0000}});
        rows.push_back('{1'b0, 15'h1801, 16'hD67F, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h1802, 16'hDA61, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h1803, 16'h0000, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h1804, 16'hF025, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h0025, 16'h3040, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h1820, 16'h41C0, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h1805, 16'h5020, 1'b0, ld_ok});
        rows.push_back('{1'b0, 15'h1806, 16'hC000, 1'b0, ld_ok});
        rows.push_back('{1'b1, 15'h7FFF, 16'hFFFF, 1'b1,
                         lc3b_pkg::result_t'{16'h3002, 1'b0, 3'b100, 1'b1, 3'd1, 16'hFFFF,
                                             2'd0, 15'h0, 16'h0}});
        repeat (6) rows.push_back('{1'b1, 15'h0000, 16'h0000, 1'b0, ld_ok});
        repeat (2) rows.push_back('{1'b1, 15'h5555, 16'hAAAA, 1'b1,
                         lc3b_pkg::result_t'{16'h0000, 1'b1, 3'b010, 1'b0, 3'd0, 16'h0,
                                             2'd0, 15'h0, 16'h0}});
        foreach (rows[i]) send(rows[i].func, rows[i].addr, rows[i].data, rows[i].chk, rows[i].res);

        cfg_vals = '{16'hFFFE, 16'h0000, 16'h3000, 16'h3000};
        cfg_vals[2] = {15'($urandom_range(32767)), 1'b0};
        for (int p = 0; p < 4; p++)
        begin
            write_start_pc(cfg_vals[p]);
            case (p)
                0:
                begin
                    src_pct = 0; snk_pct = 0; hold_request <= 400;
                end
                1:
                begin
                    src_pct = 80; snk_pct = 0;
                end
                2:
                begin
                    src_pct = 0; snk_pct = 80;
                end
                default:
                begin
                    src_pct = 8; snk_pct = 8;
                end
            endcase
            sent = 0;
            while (sent < 250)
            begin
                if (pc_m == 16'd0)
                begin
                    send(1'b1, 15'($urandom), 16'($urandom));
                    sent++;
                    write_start_pc({15'($urandom), 1'b0});
                end
                else if ($urandom_range(9) == 0)
                begin
                    send(1'b0, 15'($urandom), 16'($urandom));
                    sent++;
                end
                else
                begin
                    if (!mem_ok[pc_m[15:1]] || $urandom_range(3) == 0)
                    begin
                        ir = 16'($urandom);
                        ir[15:12] = 4'($urandom_range(15));
                        send(1'b0, pc_m[15:1], ir);
                        sent++;
                    end
                    ir = mem_m[pc_m[15:1]];
                    a = regs_m[ir[8:6]];
                    if (ir[15:12] == lc3b_pkg::OP_LDB)
                    begin
                        ad = a + sext(ir, 6);
                        ensure_word(ad[15:1]);
                    end
                    else if (ir[15:12] == lc3b_pkg::OP_LDW)
                    begin
                        ad = a + (sext(ir, 6) << 1);
                        ensure_word(ad[15:1]);
                    end
                    else if (ir[15:12] == lc3b_pkg::OP_TRAP)
                        ensure_word({7'd0, ir[7:0]});
                    send(1'b1, 15'($urandom), 16'($urandom));
                    sent++;
                end
            end
        end

        drain();
        if (fails == 0)
            $display("lc3b_instruction_executor_tb: PASS");
        else
            $display("lc3b_instruction_executor_tb: FAIL");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/lc3b_pkg.sv
hw/rtl/lc3b_instruction_executor.sv
tb/lc3b_instruction_executor_tb.sv
